### rtl/assert_macros.svh
// Assertion macros for the checker file usbep0_chk.sv.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/usbep0_pkg.sv
// Package for the USB endpoint-0 request engine: result type, codes,
// descriptor table. No dependencies.
package usbep0_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 64;
	localparam int ROM_DEPTH_DEF        = 256;
	localparam int ROM_IDX_W            = 10;
	localparam int TABLE_BYTES          = 142;

	localparam logic [1:0] KIND_CSR  = 2'd0;
	localparam logic [1:0] KIND_ADDR = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	localparam logic CMD_BUS_RESET = 1'b1;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_SEND = 2'd1;

	localparam logic [7:0] CSR_CLR_STALL  = 8'h00;
	localparam logic [7:0] CSR_SETUP_END  = 8'h80;
	localparam logic [7:0] CSR_SERVICED   = 8'h40;
	localparam logic [7:0] CSR_SVC_DEND   = 8'h48;
	localparam logic [7:0] CSR_SVC_STALL  = 8'h60;
	localparam logic [7:0] CSR_TXRDY      = 8'h02;
	localparam logic [7:0] CSR_TXRDY_DEND = 8'h0A;

	localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
	localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
	localparam logic [7:0] REQ_GET_DESC    = 8'h06;
	localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;

	localparam logic [7:0] DT_DEVICE = 8'h01;
	localparam logic [7:0] DT_CONFIG = 8'h02;
	localparam logic [7:0] DT_STRING = 8'h03;

	localparam logic [7:0] OFS_DEVICE = 8'd0;
	localparam logic [7:0] OFS_CONFIG = 8'd18;
	localparam logic [7:0] OFS_STR0   = 8'd50;
	localparam logic [7:0] OFS_STR1   = 8'd54;
	localparam logic [7:0] OFS_STR2   = 8'd72;
	localparam logic [7:0] OFS_STR3   = 8'd116;

	localparam logic [7:0] DESC_TABLE [TABLE_BYTES] = '{
		8'd18, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h40, 8'hca,
		8'h67, 8'h69, 8'hac, 8'h95, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01,
		8'd9, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h02, 8'h80, 8'd50,
		8'd9, 8'h04, 8'h00, 8'h00, 8'h02, 8'h08, 8'h06, 8'h50, 8'h00,
		8'd7, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
		8'd7, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
		8'd4, 8'h03, 8'h09, 8'h04,
		8'd18, 8'h03, 8'h4d, 8'h00, 8'h69, 8'h00, 8'h7a, 8'h00, 8'h75,
		8'h00, 8'h2d, 8'h00, 8'h44, 8'h00, 8'h45, 8'h00, 8'h43, 8'h00,
		8'd44, 8'h03, 8'h4a, 8'h00, 8'h69, 8'h00, 8'h65, 8'h00, 8'h4c,
		8'h00, 8'h69, 8'h00, 8'h20, 8'h00,
		8'h41, 8'h00, 8'h43, 8'h00, 8'h36, 8'h00, 8'h39, 8'h00, 8'h78,
		8'h00, 8'h78, 8'h00, 8'h20, 8'h00,
		8'h55, 8'h00, 8'h53, 8'h00, 8'h42, 8'h00, 8'h20, 8'h00, 8'h54,
		8'h00, 8'h65, 8'h00, 8'h73, 8'h00, 8'h74, 8'h00,
		8'd26, 8'h03, 8'h32, 8'h00, 8'h30, 8'h00, 8'h31, 8'h00, 8'h39,
		8'h00, 8'h30, 8'h00, 8'h37, 8'h00, 8'h31, 8'h00, 8'h38, 8'h00,
		8'h31, 8'h00, 8'h30, 8'h00, 8'h33, 8'h00, 8'h31, 8'h00
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  reg_value;
		logic [6:0]  plen;
		logic [31:0] word;
		logic [2:0]  nbytes;
	} res_t;

	typedef struct packed {
		logic emit;
		logic flush;
	} obuf_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} rom_ctl_t;

	function automatic logic [7:0] rom_byte(input logic [ROM_IDX_W-1:0] a);
		logic [7:0] b;
		b = 8'h00;
		if (a < ROM_IDX_W'(TABLE_BYTES))
			b = DESC_TABLE[a[7:0]];
		return b;
	endfunction

endpackage

### rtl/usbep0_rom.sv
// Descriptor ROM with its address unit: reduce modulo depth, step with wrap.
// Depends on usbep0_pkg.
module usbep0_rom #(
	parameter int ROM_DEPTH = usbep0_pkg::ROM_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  usbep0_pkg::rom_ctl_t ctl,
	input  logic [7:0]          ld_addr,
	output logic                rdy,
	output logic [7:0]          rd_byte
);
	import usbep0_pkg::*;

	localparam int AW = $clog2(ROM_DEPTH);
	localparam int WW = (AW > 8) ? AW : 8;
	localparam logic [WW:0] DEPTH_W = (WW + 1)'(ROM_DEPTH);
	localparam logic [WW:0] LAST_W  = (WW + 1)'(ROM_DEPTH - 1);

	logic [WW-1:0] addr_q;
	logic [WW:0]   addr_x;

	assign addr_x  = {1'b0, addr_q};
	assign rdy     = addr_x < DEPTH_W;
	assign rd_byte = rom_byte(ROM_IDX_W'(addr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (ctl.load) begin
			addr_q <= WW'(ld_addr);
		end else if (!rdy) begin
			addr_q <= WW'(addr_x - DEPTH_W);
		end else if (ctl.step) begin
			if (addr_x == LAST_W)
				addr_q <= '0;
			else
				addr_q <= addr_q + 1'b1;
		end
	end

endmodule

### rtl/usbep0_obuf.sv
// Result buffer: one held beat to mark the final one, then the output register.
// Depends on usbep0_pkg.
module usbep0_obuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  usbep0_pkg::obuf_ctl_t ctl,
	input  usbep0_pkg::res_t      res,
	output logic                  ok,
	output logic                  out_valid,
	input  logic                  out_stall,
	output usbep0_pkg::res_t      out_res,
	output logic                  out_last
);
	import usbep0_pkg::*;

	logic pend_v_q;
	res_t pend_q;
	logic out_v_q;
	res_t out_q;
	logic last_q;

	assign ok        = !pend_v_q || !out_v_q || !out_stall;
	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ok && pend_v_q && (ctl.emit || ctl.flush))
				out_v_q <= 1'b1;
			else if (out_v_q && !out_stall)
				out_v_q <= 1'b0;
			if (ctl.emit && ok)
				pend_v_q <= 1'b1;
			else if (ctl.flush && ok && pend_v_q)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && ok) begin
			if (pend_v_q) begin
				out_q  <= pend_q;
				last_q <= 1'b0;
			end
			pend_q <= res;
		end else if (ctl.flush && ok && pend_v_q) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

endmodule

### rtl/usb_ep0_standard_request_engine.sv
// Top level of the USB endpoint-0 standard request engine: sequencer.
// Depends on usbep0_pkg, usbep0_rom, usbep0_obuf.
//
//  channel  handshake            payload
//  in       in_valid / in_stall  cmd, status flags, setup packet fields
//  out      out_valid/ out_stall result_kind .. word_bytes, last
//
// One item at a time; for an interrupt, in_stall is high from acceptance until
// the last beat is in the output register. A bus reset is served without leaving
// idle. An interrupt passes the address, stall-clear and setup-end steps and the
// decode, then emits its beats; a get descriptor adds the length lookup and clamp,
// and a chunk reads its bytes in turn (none with the transmitter busy). Each ROM
// load waits for the modulo reduction when ROM_DEPTH < 256.
// arst_n clears mode, pending address, send pointer and count.
// out_stall holds the sequencer only when a beat has nowhere to go.
module usb_ep0_standard_request_engine #(
	parameter int MAX_PACKET_BYTES = usbep0_pkg::MAX_PACKET_BYTES_DEF,
	parameter int ROM_DEPTH        = usbep0_pkg::ROM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic        rx_packet_ready,
	input  logic        tx_packet_busy,
	input  logic        sent_stall_flag,
	input  logic        setup_end_flag,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] request_value,
	input  logic [15:0] request_index,
	input  logic [15:0] request_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  reg_value,
	output logic [6:0]  packet_length,
	output logic [31:0] data_word,
	output logic [2:0]  word_bytes,
	output logic        last
);
	import usbep0_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_ADDR    = 5'd1;
	localparam logic [4:0] S_CLRSTL  = 5'd2;
	localparam logic [4:0] S_SETEND  = 5'd3;
	localparam logic [4:0] S_DISP    = 5'd4;
	localparam logic [4:0] S_GS1     = 5'd5;
	localparam logic [4:0] S_GS2     = 5'd6;
	localparam logic [4:0] S_GS3     = 5'd7;
	localparam logic [4:0] S_ACK     = 5'd8;
	localparam logic [4:0] S_STALLRQ = 5'd9;
	localparam logic [4:0] S_LEN0    = 5'd10;
	localparam logic [4:0] S_LEN1    = 5'd11;
	localparam logic [4:0] S_LEN2    = 5'd12;
	localparam logic [4:0] S_LEN3    = 5'd13;
	localparam logic [4:0] S_CLAMP   = 5'd14;
	localparam logic [4:0] S_DACK    = 5'd15;
	localparam logic [4:0] S_CHUNK   = 5'd16;
	localparam logic [4:0] S_BYTE    = 5'd17;
	localparam logic [4:0] S_WORD    = 5'd18;
	localparam logic [4:0] S_CSR     = 5'd19;
	localparam logic [4:0] S_FLUSH   = 5'd20;

	localparam logic [7:0] MAX_B = 8'(MAX_PACKET_BYTES);

	logic [4:0]  state_q;
	logic [1:0]  mode_q;
	logic [6:0]  pend_addr_q;
	logic [7:0]  sp_q;
	logic [7:0]  rem_q;

	logic        rx_q, busy_q, stl_q, send_q;
	logic [7:0]  rtype_q, rcode_q;
	logic [15:0] rvalue_q, rlen_q;

	logic [15:0] len_q;
	logic        cfg_q;
	logic [6:0]  n_q;
	logic [6:0]  idx_q;
	logic [2:0]  wb_q;
	logic [31:0] word_q;

	logic        accept;
	logic        to_host;
	logic        found;
	logic [7:0]  base;
	logic [7:0]  dtype, didx;
	logic [4:0]  disp_next;

	obuf_ctl_t   octl;
	res_t        res;
	logic        ok;
	logic        go;
	res_t        out_res;

	rom_ctl_t    rctl;
	logic [7:0]  rom_ld;
	logic        rom_rdy;
	logic [7:0]  rom_b;

	usbep0_rom #(.ROM_DEPTH(ROM_DEPTH)) u_rom (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (rctl),
		.ld_addr (rom_ld),
		.rdy     (rom_rdy),
		.rd_byte (rom_b)
	);

	usbep0_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (octl),
		.res       (res),
		.ok        (ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.out_last  (last)
	);

	assign result_kind   = out_res.kind;
	assign reg_value     = out_res.reg_value;
	assign packet_length = out_res.plen;
	assign data_word     = out_res.word;
	assign word_bytes    = out_res.nbytes;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign to_host  = rtype_q[7];
	assign dtype    = rvalue_q[15:8];
	assign didx     = rvalue_q[7:0];

	always_comb begin
		found = 1'b1;
		base  = OFS_DEVICE;
		if (dtype == DT_DEVICE)
			base = OFS_DEVICE;
		else if (dtype == DT_CONFIG)
			base = OFS_CONFIG;
		else if (dtype == DT_STRING && didx == 8'd0)
			base = OFS_STR0;
		else if (dtype == DT_STRING && didx == 8'd1)
			base = OFS_STR1;
		else if (dtype == DT_STRING && didx == 8'd2)
			base = OFS_STR2;
		else if (dtype == DT_STRING && didx == 8'd3)
			base = OFS_STR3;
		else
			found = 1'b0;
	end

	always_comb begin
		disp_next = S_STALLRQ;
		if (rtype_q[6:0] == 7'd0) begin
			unique case (rcode_q)
				REQ_GET_STATUS: if (to_host) disp_next = S_GS1;
				REQ_SET_ADDRESS: if (!to_host) disp_next = S_ACK;
				REQ_GET_DESC: if (to_host && found) disp_next = S_LEN0;
				REQ_SET_CONFIG: if (!to_host) disp_next = S_ACK;
				default: ;
			endcase
		end
	end

	always_comb begin
		octl   = '0;
		res    = '0;
		rctl   = '0;
		rom_ld = sp_q;
		unique case (state_q)
			S_ADDR: begin
				octl.emit     = (pend_addr_q != 7'd0);
				res.kind      = KIND_ADDR;
				res.reg_value = {1'b0, pend_addr_q};
			end
			S_CLRSTL: begin
				octl.emit     = stl_q;
				res.reg_value = CSR_CLR_STALL;
			end
			S_SETEND: begin
				octl.emit     = send_q;
				res.reg_value = CSR_SETUP_END;
			end
			S_DISP: begin
				rctl.load = 1'b1;
				rom_ld    = base;
			end
			S_GS1, S_DACK: begin
				octl.emit     = 1'b1;
				res.reg_value = CSR_SERVICED;
			end
			S_GS2: begin
				octl.emit  = 1'b1;
				res.kind   = KIND_DATA;
				res.word   = 32'h0000_0001;
				res.nbytes = 3'd2;
			end
			S_GS3: begin
				octl.emit     = 1'b1;
				res.reg_value = CSR_TXRDY_DEND;
				res.plen      = 7'd2;
			end
			S_ACK: begin
				octl.emit     = 1'b1;
				res.reg_value = CSR_SVC_DEND;
			end
			S_STALLRQ: begin
				octl.emit     = 1'b1;
				res.reg_value = CSR_SVC_STALL;
			end
			S_LEN0: rctl.step = rom_rdy;
			S_LEN1, S_LEN2: rctl.step = 1'b1;
			S_CHUNK: begin
				rctl.load = 1'b1;
				rom_ld    = sp_q;
			end
			S_BYTE: rctl.step = rom_rdy && (idx_q != n_q);
			S_WORD: begin
				octl.emit  = 1'b1;
				res.kind   = KIND_DATA;
				res.word   = word_q;
				res.nbytes = wb_q;
			end
			S_CSR: begin
				octl.emit     = 1'b1;
				res.reg_value = (rem_q == {1'b0, n_q}) ? CSR_TXRDY_DEND : CSR_TXRDY;
				res.plen      = n_q;
			end
			S_FLUSH: octl.flush = 1'b1;
			default: ;
		endcase
	end

	assign go = !octl.emit || ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_IDLE;
			pend_addr_q <= '0;
			sp_q        <= '0;
			rem_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_BUS_RESET) begin
							mode_q      <= MODE_IDLE;
							pend_addr_q <= '0;
						end else begin
							state_q <= S_ADDR;
						end
					end
				end
				S_ADDR: begin
					if (go) begin
						pend_addr_q <= '0;
						state_q     <= S_CLRSTL;
					end
				end
				S_CLRSTL: begin
					if (go) begin
						if (stl_q)
							mode_q <= MODE_IDLE;
						state_q <= S_SETEND;
					end
				end
				S_SETEND: begin
					if (go) begin
						if (send_q)
							mode_q <= MODE_IDLE;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (mode_q == MODE_SEND) begin
						state_q <= S_CHUNK;
					end else if (mode_q == MODE_IDLE && rx_q) begin
						state_q <= disp_next;
						if (disp_next == S_ACK && rcode_q == REQ_SET_ADDRESS)
							pend_addr_q <= rvalue_q[6:0];
						if (disp_next == S_LEN0)
							sp_q <= base;
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_GS1: if (go) state_q <= S_GS2;
				S_GS2: if (go) state_q <= S_GS3;
				S_GS3, S_ACK, S_STALLRQ: if (go) state_q <= S_FLUSH;
				S_LEN0: if (rom_rdy) state_q <= S_LEN1;
				S_LEN1: state_q <= S_LEN2;
				S_LEN2: state_q <= S_LEN3;
				S_LEN3: state_q <= S_CLAMP;
				S_CLAMP: begin
					rem_q   <= (len_q > rlen_q) ? rlen_q[7:0] : len_q[7:0];
					mode_q  <= MODE_SEND;
					state_q <= S_DACK;
				end
				S_DACK: if (go) state_q <= S_CHUNK;
				S_CHUNK: state_q <= busy_q ? S_FLUSH : S_BYTE;
				S_BYTE: begin
					if (idx_q == n_q)
						state_q <= S_CSR;
					else if (rom_rdy && (wb_q == 3'd3 || idx_q + 7'd1 == n_q))
						state_q <= S_WORD;
				end
				S_WORD: if (go) state_q <= S_BYTE;
				S_CSR: begin
					if (go) begin
						sp_q  <= sp_q + {1'b0, n_q};
						rem_q <= rem_q - {1'b0, n_q};
						if (rem_q == {1'b0, n_q})
							mode_q <= MODE_IDLE;
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: if (ok) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_q     <= rx_packet_ready;
			busy_q   <= tx_packet_busy;
			stl_q    <= sent_stall_flag;
			send_q   <= setup_end_flag;
			rtype_q  <= request_type;
			rcode_q  <= request_code;
			rvalue_q <= request_value;
			rlen_q   <= request_length;
		end
		case (state_q)
			S_LEN0: len_q <= {8'h00, rom_b};
			S_LEN1: cfg_q <= (rom_b == DT_CONFIG);
			S_LEN2: if (cfg_q) len_q[7:0] <= rom_b;
			S_LEN3: if (cfg_q) len_q[15:8] <= rom_b;
			S_CHUNK: begin
				n_q    <= (rem_q > MAX_B) ? MAX_B[6:0] : rem_q[6:0];
				idx_q  <= '0;
				wb_q   <= '0;
				word_q <= '0;
			end
			S_BYTE: begin
				if (idx_q != n_q && rom_rdy) begin
					word_q[{wb_q[1:0], 3'b000} +: 8] <= rom_b;
					wb_q  <= wb_q + 3'd1;
					idx_q <= idx_q + 7'd1;
				end
			end
			S_WORD: begin
				if (go) begin
					word_q <= '0;
					wb_q   <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/usbep0_chk.sv
// Port-level checker for the endpoint-0 request engine, bound to the top.
// Depends on usbep0_pkg and assert_macros.svh.
`include "assert_macros.svh"

module usbep0_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] request_index,
	input logic [7:0]  request_code,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  result_kind,
	input logic [7:0]  reg_value,
	input logic [6:0]  packet_length,
	input logic [31:0] data_word,
	input logic [2:0]  word_bytes
);
	import usbep0_pkg::*;

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(result_kind) && $stable(data_word) && $stable(reg_value))
	`ASSERT_NEXT(a_in_hold, in_valid && in_stall,
		$stable(request_index) && $stable(request_code))
	`ASSERT_IMPL(a_kind, out_valid, result_kind != 2'd3)
	`ASSERT_IMPL(a_data_beat, out_valid && result_kind == KIND_DATA,
		word_bytes != 3'd0 && word_bytes <= 3'd4 && reg_value == 8'h00)
	`ASSERT_IMPL(a_plen, out_valid && packet_length != 7'd0,
		result_kind == KIND_CSR && reg_value[1] && packet_length <= 7'd64)

endmodule

bind usb_ep0_standard_request_engine usbep0_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.request_index (request_index),
	.request_code  (request_code),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.result_kind   (result_kind),
	.reg_value     (reg_value),
	.packet_length (packet_length),
	.data_word     (data_word),
	.word_bytes    (word_bytes)
);

### test/usb_ep0_standard_request_engine_tb.sv
`timescale 1ns / 100ps
// Testbench for usb_ep0_standard_request_engine: a directed event table, then
// random control-endpoint traffic, each beat checked against its table row
// or an in-bench model. Depends on usbep0_pkg and the engine RTL.
module usb_ep0_standard_request_engine_tb;
	import usbep0_pkg::*;

	localparam logic CMD_IRQ = 1'b0;
	localparam logic [7:0] RT_TO_DEV = 8'h00;
	localparam logic [7:0] RT_TO_HOST = 8'h80;
	localparam logic [7:0] RT_EP_TO_HOST = 8'h82;
	localparam int MAX_PKT = 64;
	localparam int ROM_SIZE = 256;
	localparam int DESC_LEN = 142;
	localparam int RAND_PER_PHASE = 48;
	localparam int N_DIR = 26;

	typedef struct packed {
		logic        cmd;
		logic        rxr;
		logic        busy;
		logic        stl;
		logic        sue;
		logic [7:0]  rtype;
		logic [7:0]  rcode;
		logic [15:0] rvalue;
		logic [15:0] rindex;
		logic [15:0] rlength;
	} ep0_event_t;

	typedef struct packed {
		logic       typed;
		logic       t_cnt;
		logic [1:0] t_kind;
		logic [7:0] t_reg;
		ep0_event_t ev;
	} dir_row_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  regv;
		logic [6:0]  plen;
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} ep0_beat_t;

	localparam logic [7:0] DESC_BYTES [DESC_LEN] = '{
		8'h12, 8'h01, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, 8'h40, 8'hca,
		8'h67, 8'h69, 8'hac, 8'h95, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01,
		8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h02, 8'h80, 8'h32,
		8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h08, 8'h06, 8'h50, 8'h00,
		8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00,
		8'h07, 8'h05, 8'h01, 8'h02, 8'h40, 8'h00, 8'h00,
		8'h04, 8'h03, 8'h09, 8'h04,
		8'h12, 8'h03, 8'h4d, 8'h00, 8'h69, 8'h00, 8'h7a, 8'h00, 8'h75,
		8'h00, 8'h2d, 8'h00, 8'h44, 8'h00, 8'h45, 8'h00, 8'h43, 8'h00,
		8'h2c, 8'h03, 8'h4a, 8'h00, 8'h69, 8'h00, 8'h65, 8'h00, 8'h4c,
		8'h00, 8'h69, 8'h00, 8'h20, 8'h00,
		8'h41, 8'h00, 8'h43, 8'h00, 8'h36, 8'h00, 8'h39, 8'h00, 8'h78,
		8'h00, 8'h78, 8'h00, 8'h20, 8'h00,
		8'h55, 8'h00, 8'h53, 8'h00, 8'h42, 8'h00, 8'h20, 8'h00, 8'h54,
		8'h00, 8'h65, 8'h00, 8'h73, 8'h00, 8'h74, 8'h00,
		8'h1a, 8'h03, 8'h32, 8'h00, 8'h30, 8'h00, 8'h31, 8'h00, 8'h39,
		8'h00, 8'h30, 8'h00, 8'h37, 8'h00, 8'h31, 8'h00, 8'h38, 8'h00,
		8'h31, 8'h00, 8'h30, 8'h00, 8'h33, 8'h00, 8'h31, 8'h00
	};

	// typed, count, kind, reg | cmd, rxr, busy, stall, setup end, setup packet
	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{1'b1, 1'b0, KIND_CSR, 8'h00, '{CMD_BUS_RESET, 1'b1, 1'b1, 1'b1, 1'b1,
			8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
		'{1'b1, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b0, 1'b0, 1'b0, 1'b0,
			8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_CSR, CSR_CLR_STALL, '{CMD_IRQ, 1'b0, 1'b0, 1'b1, 1'b0,
			8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SETUP_END, '{CMD_IRQ, 1'b0, 1'b0, 1'b0, 1'b1,
			8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_STALL, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_HOST, 8'hFF, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_STALL, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			8'hFF, REQ_GET_STATUS, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_STALL, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_DEV, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_HOST, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_DEND, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_DEV, REQ_SET_CONFIG, 16'h0001, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_DEND, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_DEV, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_ADDR, 8'h7F, '{CMD_IRQ, 1'b0, 1'b0, 1'b0, 1'b0,
			8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_DEND, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_DEV, REQ_SET_ADDRESS, 16'h0080, 16'h0000, 16'h0000}},
		'{1'b1, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b0, 1'b0, 1'b0, 1'b0,
			8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_STALL, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_EP_TO_HOST, REQ_GET_DESC, 16'h0100, 16'h0000, 16'hFFFF}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_HOST, REQ_GET_DESC, 16'h0100, 16'h0000, 16'hFFFF}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b1, 1'b1, 1'b0, 1'b0,
			RT_TO_HOST, REQ_GET_DESC, 16'h0200, 16'h0000, 16'hFFFF}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b0, 1'b0, 1'b0, 1'b0,
			8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_HOST, REQ_GET_DESC, 16'h0302, 16'h0000, 16'h0000}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_STALL, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_HOST, REQ_GET_DESC, 16'h0304, 16'h0000, 16'h0040}},
		'{1'b1, 1'b1, KIND_CSR, CSR_SVC_STALL, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_HOST, REQ_GET_DESC, 16'hFFFF, 16'h0000, 16'hFFFF}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b1, 1'b1, 1'b0, 1'b0,
			RT_TO_HOST, REQ_GET_DESC, 16'h0300, 16'h0000, 16'h0003}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b1, 1'b0, 1'b1, 1'b1,
			RT_TO_HOST, REQ_GET_DESC, 16'h0303, 16'h0000, 16'h0020}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b1, 1'b0, 1'b0, 1'b0,
			RT_TO_DEV, REQ_SET_ADDRESS, 16'h002A, 16'h0000, 16'h0000}},
		'{1'b0, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b1, 1'b1, 1'b0, 1'b0,
			RT_TO_HOST, REQ_GET_DESC, 16'h0301, 16'h0000, 16'hFFFF}},
		'{1'b1, 1'b0, KIND_CSR, 8'h00, '{CMD_BUS_RESET, 1'b0, 1'b0, 1'b0, 1'b0,
			8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}},
		'{1'b1, 1'b0, KIND_CSR, 8'h00, '{CMD_IRQ, 1'b0, 1'b0, 1'b0, 1'b0,
			8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000}}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic        rx_packet_ready;
	logic        tx_packet_busy;
	logic        sent_stall_flag;
	logic        setup_end_flag;
	logic [7:0]  request_type;
	logic [7:0]  request_code;
	logic [15:0] request_value;
	logic [15:0] request_index;
	logic [15:0] request_length;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [7:0]  reg_value;
	logic [6:0]  packet_length;
	logic [31:0] data_word;
	logic [2:0]  word_bytes;
	logic        last;

	ep0_beat_t   expected_beats[$];
	ep0_beat_t   event_beats[$];
	logic [1:0]  ep_mode;
	logic [6:0]  addr_pending;
	logic [7:0]  tx_ptr;
	logic [7:0]  tx_left;
	logic [7:0]  desc_rom [ROM_SIZE];
	int          send_idle_pct;
	int          recv_stall_pct;
	int          mism = 0;

	usb_ep0_standard_request_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.rx_packet_ready(rx_packet_ready),
		.tx_packet_busy(tx_packet_busy),
		.sent_stall_flag(sent_stall_flag),
		.setup_end_flag(setup_end_flag),
		.request_type(request_type),
		.request_code(request_code),
		.request_value(request_value),
		.request_index(request_index),
		.request_length(request_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.reg_value(reg_value),
		.packet_length(packet_length),
		.data_word(data_word),
		.word_bytes(word_bytes),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic add_beat(input logic [1:0] k, input logic [7:0] v, input logic [6:0] pl,
		input logic [31:0] w, input logic [2:0] nb);
		event_beats.push_back('{k, v, pl, w, nb, 1'b0});
	endtask

	// one IN packet from the descriptor pointer, unless the transmitter is busy
	task automatic load_tx_chunk(input logic busy);
		int n;
		int cnt;
		logic [31:0] w;
		if (!busy) begin
			n = (tx_left > MAX_PKT) ? MAX_PKT : int'(tx_left);
			for (int i = 0; i < n; i += 4) begin
				cnt = (n - i > 4) ? 4 : n - i;
				w = '0;
				for (int j = 0; j < cnt; j++)
					w[8*j +: 8] = desc_rom[(int'(tx_ptr) + i + j) % ROM_SIZE];
				add_beat(KIND_DATA, 8'h00, 7'd0, w, 3'(cnt));
			end
			tx_ptr = tx_ptr + 8'(n);
			tx_left = tx_left - 8'(n);
			if (tx_left == 8'd0) begin
				add_beat(KIND_CSR, CSR_TXRDY_DEND, 7'(n), 32'd0, 3'd0);
				ep_mode = MODE_IDLE;
			end else begin
				add_beat(KIND_CSR, CSR_TXRDY, 7'(n), 32'd0, 3'd0);
			end
		end
	endtask

	task automatic serve_event(input ep0_event_t e);
		logic stall;
		logic ack;
		logic found;
		logic to_host;
		logic [7:0] base;
		logic [15:0] dlen;
		ep0_beat_t b;
		event_beats.delete();
		if (e.cmd == CMD_BUS_RESET) begin
			ep_mode = MODE_IDLE;
			addr_pending = '0;
		end else begin
			if (addr_pending != 7'd0) begin
				add_beat(KIND_ADDR, {1'b0, addr_pending}, 7'd0, 32'd0, 3'd0);
				addr_pending = '0;
			end
			if (e.stl) begin
				add_beat(KIND_CSR, CSR_CLR_STALL, 7'd0, 32'd0, 3'd0);
				ep_mode = MODE_IDLE;
			end
			if (e.sue) begin
				add_beat(KIND_CSR, CSR_SETUP_END, 7'd0, 32'd0, 3'd0);
				ep_mode = MODE_IDLE;
			end
			if (ep_mode == MODE_SEND) begin
				load_tx_chunk(e.busy);
			end else if (ep_mode == MODE_IDLE && e.rxr) begin
				stall = 1'b1;
				ack = 1'b1;
				to_host = e.rtype[7];
				if (e.rtype[6:0] == 7'd0) begin
					if (e.rcode == REQ_GET_STATUS && to_host) begin
						add_beat(KIND_CSR, CSR_SERVICED, 7'd0, 32'd0, 3'd0);
						add_beat(KIND_DATA, 8'h00, 7'd0, 32'h0000_0001, 3'd2);
						add_beat(KIND_CSR, CSR_TXRDY_DEND, 7'd2, 32'd0, 3'd0);
						stall = 1'b0;
						ack = 1'b0;
					end else if (e.rcode == REQ_SET_ADDRESS && !to_host) begin
						addr_pending = e.rvalue[6:0];
						stall = 1'b0;
					end else if (e.rcode == REQ_GET_DESC && to_host) begin
						found = 1'b1;
						base = OFS_DEVICE;
						case (e.rvalue[15:8])
						DT_DEVICE: base = OFS_DEVICE;
						DT_CONFIG: base = OFS_CONFIG;
						DT_STRING: begin
							case (e.rvalue[7:0])
							8'd0: base = OFS_STR0;
							8'd1: base = OFS_STR1;
							8'd2: base = OFS_STR2;
							8'd3: base = OFS_STR3;
							default: found = 1'b0;
							endcase
						end
						default: found = 1'b0;
						endcase
						ack = 1'b0;
						if (found) begin
							// config descriptors report their total length
							dlen = {8'd0, desc_rom[base]};
							if (desc_rom[base + 1] == DT_CONFIG)
								dlen = {desc_rom[base + 3], desc_rom[base + 2]};
							if (dlen > e.rlength)
								dlen = e.rlength;
							add_beat(KIND_CSR, CSR_SERVICED, 7'd0, 32'd0, 3'd0);
							tx_ptr = base;
							tx_left = dlen[7:0];
							ep_mode = MODE_SEND;
							load_tx_chunk(e.busy);
							stall = 1'b0;
						end
					end else if (e.rcode == REQ_SET_CONFIG && !to_host) begin
						stall = 1'b0;
					end
				end
				if (stall)
					add_beat(KIND_CSR, CSR_SVC_STALL, 7'd0, 32'd0, 3'd0);
				else if (ack)
					add_beat(KIND_CSR, CSR_SVC_DEND, 7'd0, 32'd0, 3'd0);
			end
			if (event_beats.size() != 0) begin
				b = event_beats.pop_back();
				b.last = 1'b1;
				event_beats.push_back(b);
			end
		end
	endtask

	function automatic ep0_event_t rand_event();
		ep0_event_t e;
		int r;
		logic [7:0] dtype;
		e.cmd = ($urandom_range(99) < 5) ? CMD_BUS_RESET : CMD_IRQ;
		e.rxr = ($urandom_range(99) < 80);
		e.busy = ($urandom_range(99) < 25);
		e.stl = ($urandom_range(99) < 10);
		e.sue = ($urandom_range(99) < 10);
		e.rindex = 16'($urandom);
		e.rvalue = 16'($urandom);
		r = $urandom_range(99);
		e.rlength = (r < 75) ? 16'($urandom_range(64)) : (r < 88) ? 16'hFFFF : 16'($urandom);
		case ($urandom_range(9))
		0: begin
			e.rtype = RT_TO_HOST;
			e.rcode = REQ_GET_STATUS;
		end
		1: begin
			e.rtype = RT_TO_DEV;
			e.rcode = REQ_SET_ADDRESS;
		end
		2: begin
			e.rtype = RT_TO_DEV;
			e.rcode = REQ_SET_CONFIG;
		end
		3, 4, 5, 6: begin
			e.rtype = RT_TO_HOST;
			e.rcode = REQ_GET_DESC;
			case ($urandom_range(4))
			0: dtype = DT_DEVICE;
			1: dtype = DT_CONFIG;
			4: dtype = 8'($urandom);
			default: dtype = DT_STRING;
			endcase
			e.rvalue = {dtype, ($urandom_range(3) != 0) ? 8'($urandom_range(4)) : 8'($urandom)};
		end
		default: begin
			e.rtype = ($urandom_range(1) != 0) ? 8'($urandom) : (RT_TO_HOST & 8'($urandom));
			e.rcode = ($urandom_range(1) != 0) ? 8'($urandom) : 8'($urandom_range(12));
		end
		endcase
		return e;
	endfunction

	task automatic send_event(input dir_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cmd <= row.ev.cmd;
		rx_packet_ready <= row.ev.rxr;
		tx_packet_busy <= row.ev.busy;
		sent_stall_flag <= row.ev.stl;
		setup_end_flag <= row.ev.sue;
		request_type <= row.ev.rtype;
		request_code <= row.ev.rcode;
		request_value <= row.ev.rvalue;
		request_index <= row.ev.rindex;
		request_length <= row.ev.rlength;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		serve_event(row.ev);
		if (row.typed) begin
			if (row.t_cnt)
				expected_beats.push_back('{row.t_kind, row.t_reg, 7'd0, 32'd0, 3'd0, 1'b1});
		end else begin
			foreach (event_beats[i])
				expected_beats.push_back(event_beats[i]);
		end
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin : check_beats
		ep0_beat_t got;
		ep0_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{result_kind, reg_value, packet_length, data_word, word_bytes, last};
			if (expected_beats.size() == 0) begin
				mism++;
				if (mism <= 10)
					$display("unexpected beat: kind %0d reg %h plen %0d word %h bytes %0d last %b",
						got.kind, got.regv, got.plen, got.word, got.nbytes, got.last);
			end else begin
				want = expected_beats.pop_front();
				if (got.kind !== want.kind || got.regv !== want.regv || got.plen !== want.plen ||
					got.word !== want.word || got.nbytes !== want.nbytes ||
					got.last !== want.last) begin
					mism++;
					if (mism <= 10)
						$display("beat mismatch (exp/got): kind %0d/%0d reg %h/%h plen %0d/%0d %s",
							want.kind, got.kind, want.regv, got.regv, want.plen, got.plen,
							$sformatf("word %h/%h bytes %0d/%0d last %b/%b", want.word,
							got.word, want.nbytes, got.nbytes, want.last, got.last));
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("usb_ep0_standard_request_engine_tb: FAIL");
		$finish;
	end

	initial begin
		dir_row_t row;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cmd = CMD_IRQ;
		rx_packet_ready = 1'b0;
		tx_packet_busy = 1'b0;
		sent_stall_flag = 1'b0;
		setup_end_flag = 1'b0;
		request_type = '0;
		request_code = '0;
		request_value = '0;
		request_index = '0;
		request_length = '0;
		send_idle_pct = 12;
		recv_stall_pct = 76;
		ep_mode = MODE_IDLE;
		addr_pending = '0;
		tx_ptr = '0;
		tx_left = '0;
		for (int i = 0; i < ROM_SIZE; i++)
			desc_rom[i] = (i < DESC_LEN) ? DESC_BYTES[i] : 8'h00;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_event(DIR_TAB[i]);

		// sender idles at 12%, then 76%, then never; drain between phases
		for (int ph = 0; ph < 3; ph++) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while (expected_beats.size() != 0)
				@(negedge clk);
			send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 76 : 0;
			recv_stall_pct = (ph == 0) ? 76 : (ph == 1) ? 12 : 0;
			repeat (RAND_PER_PHASE) begin
				row = '0;
				row.ev = rand_event();
				send_event(row);
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (200) @(posedge clk);
		if (mism == 0 && expected_beats.size() == 0)
			$display("usb_ep0_standard_request_engine_tb: PASS");
		else
			$display("usb_ep0_standard_request_engine_tb: FAIL");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/usbep0_pkg.sv
rtl/usbep0_rom.sv
rtl/usbep0_obuf.sv
rtl/usb_ep0_standard_request_engine.sv
rtl/usbep0_chk.sv
test/usb_ep0_standard_request_engine_tb.sv
